### rtl/pru_pkg.sv
package pru_pkg;

	// filter kinds as carried per row; any tag above paeth maps to bad
	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4,
		FLT_BAD   = 3'd5
	} flt_kind_t;

	// configuration register indexes
	localparam logic [1:0] CFG_COLORS  = 2'd0;
	localparam logic [1:0] CFG_BPC     = 2'd1;
	localparam logic [1:0] CFG_COLUMNS = 2'd2;

	localparam int BYTE_W    = 8;
	localparam int COLORS_W  = 3;
	localparam int BPC_W     = 5;
	localparam int COLUMNS_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;
	localparam int HIST_N    = 8;
	localparam int BPP_W     = 3;

	// control from the stage register to the reconstruction unit
	typedef struct packed {
		logic              adv_data;
		logic              clear;
		flt_kind_t         kind;
		logic [BPP_W-1:0]  bpp_m1;
	} recon_ctl_t;

endpackage

### rtl/pru_ram.sv
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/pru_recon.sv
module pru_recon (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pru_pkg::recon_ctl_t  ctl,
	input  logic [7:0]           x_byte,
	input  logic [7:0]           up_byte,
	output logic [7:0]           res_byte
);
	import pru_pkg::*;

	logic [BYTE_W-1:0] left_q   [HIST_N];
	logic [BYTE_W-1:0] upleft_q [HIST_N];
	logic [BYTE_W-1:0] a_w;
	logic [BYTE_W-1:0] c_w;
	logic [BYTE_W-1:0] pred_w;
	logic [BYTE_W-1:0] paeth_w;
	logic [BYTE_W:0]   avg_sum_w;
	logic signed [9:0] p_w;
	logic [9:0]        pa_w;
	logic [9:0]        pb_w;
	logic [9:0]        pc_w;

	function automatic logic [9:0] abs10(input logic signed [9:0] v);
		abs10 = v[9] ? 10'(-v) : 10'(v);
	endfunction

	// left and up-left taps one pixel back
	assign a_w = left_q[ctl.bpp_m1];
	assign c_w = upleft_q[ctl.bpp_m1];

	// paeth predictor, ties go to left then up
	always_comb begin
		p_w  = $signed({2'b00, a_w}) + $signed({2'b00, up_byte}) - $signed({2'b00, c_w});
		pa_w = abs10(p_w - $signed({2'b00, a_w}));
		pb_w = abs10(p_w - $signed({2'b00, up_byte}));
		pc_w = abs10(p_w - $signed({2'b00, c_w}));
		if (pa_w <= pb_w && pa_w <= pc_w) begin
			paeth_w = a_w;
		end else if (pb_w <= pc_w) begin
			paeth_w = up_byte;
		end else begin
			paeth_w = c_w;
		end
	end

	assign avg_sum_w = {1'b0, a_w} + {1'b0, up_byte};

	// prediction by filter kind
	always_comb begin
		case (ctl.kind)
			FLT_NONE:  pred_w = '0;
			FLT_SUB:   pred_w = a_w;
			FLT_UP:    pred_w = up_byte;
			FLT_AVG:   pred_w = avg_sum_w[BYTE_W:1];
			FLT_PAETH: pred_w = paeth_w;
			default:   pred_w = '0;
		endcase
	end

	assign res_byte = x_byte + pred_w;

	// decoded and up history, newest in entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_N; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < HIST_N; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else if (ctl.adv_data) begin
			for (int i = HIST_N - 1; i > 0; i--) begin
				left_q[i]   <= left_q[i-1];
				upleft_q[i] <= upleft_q[i-1];
			end
			left_q[0]   <= res_byte;
			upleft_q[0] <= up_byte;
		end
	end

endmodule

### rtl/png_row_unfilter_unit.sv
// data path: an accepted data byte moves through stage one, then the output register
// throughput: one request per cycle while the sink is not stalling, tag bytes included;
//   the row store is read at accept and written back one stage later, so a byte never
//   waits on its own row entry; reset: control cleared, registers back to colors 1, 8 bits,
//   1 column; the row store has no clearing pass, a fill count makes never-written entries read as zero
module png_row_unfilter_unit #(
	parameter int MAX_ROW_BYTES = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] decoded_byte
	output logic        m_tlast,
	output logic        m_tuser,    // [0] bad_filter
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pru_pkg::CFG_DAT_W-1:0] cfg_data
);
	import pru_pkg::*;

	localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1) > 0 ? $clog2(MAX_ROW_BYTES + 1) : 1;
	localparam int CC_W   = COLUMNS_W + COLORS_W;
	localparam int BITS_W = CC_W + BPC_W;
	localparam int RB_W   = BITS_W - 2;
	localparam logic [RB_W-1:0] MAX_RB = RB_W'(MAX_ROW_BYTES);

	// configuration registers
	logic [COLORS_W-1:0]  colors_q;
	logic [BPC_W-1:0]     bpc_q;
	logic [COLUMNS_W-1:0] columns_q;
	logic                 cfg_hit;

	// front state
	logic                 tag_wait_q;
	logic [ADDR_W-1:0]    col_q;
	flt_kind_t            kind_q;
	logic [CNT_W-1:0]     fill_q;

	// stage one
	logic                 valid_s1;
	logic                 tag_s1;
	logic [BYTE_W-1:0]    x_s1;
	logic [ADDR_W-1:0]    idx_s1;
	logic                 last_s1;
	logic                 b_ok_s1;
	flt_kind_t            kind_s1;

	// output register
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	logic                 in_acc;
	logic                 data_acc;
	logic                 adv_s1;
	logic                 data_adv;
	logic [CC_W-1:0]      cc_w;
	logic [BITS_W-1:0]    bits_w;
	logic [BITS_W:0]      bits_rnd_w;
	logic [RB_W-1:0]      rb_w;
	logic [CNT_W-1:0]     rows_w;
	logic [7:0]           pix_bits_w;
	logic [4:0]           pix_bytes_w;
	logic [BPP_W-1:0]     bpp_m1_w;
	logic [CNT_W-1:0]     col_next_w;
	logic                 last_w;
	logic [BYTE_W-1:0]    ram_rdata;
	logic [BYTE_W-1:0]    up_w;
	logic [BYTE_W-1:0]    res_w;
	recon_ctl_t           ctl_w;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_COLORS || cfg_index == CFG_BPC
		|| cfg_index == CFG_COLUMNS);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q  <= COLORS_W'(1);
			bpc_q     <= BPC_W'(8);
			columns_q <= COLUMNS_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COLORS:  colors_q  <= cfg_data[COLORS_W-1:0];
				CFG_BPC:     bpc_q     <= cfg_data[BPC_W-1:0];
				CFG_COLUMNS: columns_q <= cfg_data[COLUMNS_W-1:0];
				default:     ;
			endcase
		end
	end

	// row length in bytes, clamped to one and to the store depth
	always_comb begin
		cc_w       = CC_W'(columns_q) * CC_W'(colors_q);
		bits_w     = BITS_W'(cc_w) * BITS_W'(bpc_q);
		bits_rnd_w = {1'b0, bits_w} + (BITS_W+1)'(7);
		rb_w       = bits_rnd_w[BITS_W:3];
		if (rb_w == '0) begin
			rows_w = CNT_W'(1);
		end else if (rb_w > MAX_RB) begin
			rows_w = CNT_W'(MAX_ROW_BYTES);
		end else begin
			rows_w = CNT_W'(rb_w);
		end
	end

	// pixel size in bytes, one to eight
	always_comb begin
		pix_bits_w  = 8'(colors_q) * 8'(bpc_q);
		pix_bytes_w = pix_bits_w[7:3];
		if (pix_bytes_w == '0) begin
			bpp_m1_w = '0;
		end else if (pix_bytes_w > 5'(HIST_N)) begin
			bpp_m1_w = BPP_W'(HIST_N - 1);
		end else begin
			bpp_m1_w = BPP_W'(pix_bytes_w - 5'd1);
		end
	end

	// handshake and stage advance
	assign adv_s1   = valid_s1 && (tag_s1 || !out_valid_q || m_tready);
	assign data_adv = adv_s1 && !tag_s1;
	assign s_tready = !valid_s1 || adv_s1;
	assign in_acc   = s_tvalid && s_tready;
	assign data_acc = in_acc && !tag_wait_q;

	assign col_next_w = CNT_W'(col_q) + CNT_W'(1);
	assign last_w     = col_next_w >= rows_w;

	// row position and filter tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_wait_q <= 1'b1;
			col_q      <= '0;
			kind_q     <= FLT_NONE;
		end else if (cfg_hit) begin
			tag_wait_q <= 1'b1;
			col_q      <= '0;
		end else if (in_acc) begin
			if (tag_wait_q) begin
				tag_wait_q <= 1'b0;
				col_q      <= '0;
				kind_q     <= (s_tdata > 8'd4) ? FLT_BAD : flt_kind_t'(s_tdata[2:0]);
			end else begin
				tag_wait_q <= last_w;
				col_q      <= last_w ? '0 : col_next_w[ADDR_W-1:0];
			end
		end
	end

	// fill count: row store entries are always written from zero upward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (data_adv && CNT_W'(idx_s1) == fill_q
			&& fill_q != CNT_W'(MAX_ROW_BYTES)) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_s1  <= tag_wait_q;
			x_s1    <= s_tdata;
			idx_s1  <= col_q;
			last_s1 <= last_w;
			b_ok_s1 <= CNT_W'(col_q) < fill_q;
			kind_s1 <= kind_q;
		end
	end

	// previous row store
	pru_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_ROW_BYTES)
	) u_row_ram (
		.clk   (clk),
		.we    (data_adv),
		.waddr (idx_s1),
		.wdata (res_w),
		.re    (data_acc),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign up_w = b_ok_s1 ? ram_rdata : '0;

	always_comb begin
		ctl_w.adv_data = data_adv;
		ctl_w.clear    = cfg_hit || (adv_s1 && tag_s1);
		ctl_w.kind     = kind_s1;
		ctl_w.bpp_m1   = bpp_m1_w;
	end

	pru_recon u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_w),
		.x_byte   (x_s1),
		.up_byte  (up_w),
		.res_byte (res_w)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (data_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_adv) begin
			out_byte_q <= res_w;
			out_last_q <= last_s1;
			out_bad_q  <= (kind_s1 == FLT_BAD);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

	// fill count stays within the store
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ROW_BYTES))
		else $error("fill count beyond row store depth");

	// a stalled stage one blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !s_tready)
		else $error("request taken while stage one is stalled");

	// every written entry lies below the fill count afterwards
	a_write_filled: assert property (@(posedge clk) disable iff (!arst_n)
		data_adv |=> (CNT_W'($past(idx_s1)) < fill_q))
		else $error("row store write outside filled range");

	// a pending result is not overwritten while the sink stalls
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !data_adv)
		else $error("output register overrun");

endmodule

### tb/sv/png_row_unfilter_unit_tb.sv
module png_row_unfilter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pru_pkg::*;

	localparam int MAX_ROW = 32768;
	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int RAND_ITEMS = 800;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// one decoded byte as seen on the master side
	typedef struct packed {
		logic [7:0] dec;
		logic       last;
		logic       bad;
	} decoded_t;

	// directed step: a register write, or one stream byte with an optional typed result
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] val;
		logic                 typed;
		logic [7:0]           dec;
		logic                 last;
		logic                 bad;
	} dir_step_t;

	localparam int DIR_N = 34;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	png_row_unfilter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [COLORS_W-1:0]  cfg_colors = 3'd1;
	logic [BPC_W-1:0]     cfg_bpc = 5'd8;
	logic [COLUMNS_W-1:0] cfg_columns = 13'd1;
	logic [7:0] prev_row [MAX_ROW];
	logic [7:0] left_hist [HIST_N];
	logic [7:0] upl_hist [HIST_N];
	int unsigned col_pos = 0;
	flt_kind_t row_kind = FLT_NONE;

	decoded_t decoded_q [$];
	int err_count = 0;
	int unsigned cycles = 0;
	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	int snk_stall = 0;

	initial begin
		foreach (prev_row[i]) prev_row[i] = '0;
		foreach (left_hist[i]) begin
			left_hist[i] = '0;
			upl_hist[i] = '0;
		end
	end

	function automatic int row_len();
		int unsigned n;
		n = (int'(cfg_columns) * int'(cfg_colors) * int'(cfg_bpc) + 7) / 8;
		if (n < 1) n = 1;
		if (n > MAX_ROW) n = MAX_ROW;
		return n;
	endfunction

	function automatic int pix_bytes();
		int n;
		n = (int'(cfg_colors) * int'(cfg_bpc)) / 8;
		if (n < 1) n = 1;
		if (n > HIST_N) n = HIST_N;
		return n;
	endfunction

	function automatic void clear_hist();
		foreach (left_hist[i]) begin
			left_hist[i] = '0;
			upl_hist[i] = '0;
		end
	endfunction

	// advance the row state by one stream byte; returns 1 when a decoded byte comes out
	function automatic bit unfilter_byte(input logic [7:0] x, output decoded_t r);
		int rl, bpp, pos, a, b, c, p, pa, pb, pc, pred;
		r = '0;
		rl = row_len();
		bpp = pix_bytes();
		if (col_pos == 0) begin
			row_kind = (x > 8'(FLT_PAETH)) ? FLT_BAD : flt_kind_t'(x[2:0]);
			clear_hist();
			col_pos = 1;
			return 1'b0;
		end
		pos = (col_pos - 1) % MAX_ROW;
		a = left_hist[bpp-1];
		b = prev_row[pos];
		c = upl_hist[bpp-1];
		case (row_kind)
			FLT_NONE: pred = 0;
			FLT_SUB:  pred = a;
			FLT_UP:   pred = b;
			FLT_AVG:  pred = (a + b) / 2;
			FLT_PAETH: begin
				p = a + b - c;
				pa = (p > a) ? p - a : a - p;
				pb = (p > b) ? p - b : b - p;
				pc = (p > c) ? p - c : c - p;
				if (pa <= pb && pa <= pc) pred = a;
				else if (pb <= pc) pred = b;
				else pred = c;
			end
			default: begin
				pred = 0;
				r.bad = 1'b1;
			end
		endcase
		r.dec = 8'(int'(x) + pred);
		for (int i = HIST_N - 1; i > 0; i--) begin
			left_hist[i] = left_hist[i-1];
			upl_hist[i] = upl_hist[i-1];
		end
		left_hist[0] = r.dec;
		upl_hist[0] = 8'(b);
		prev_row[pos] = r.dec;
		r.last = (col_pos >= rl);
		col_pos = r.last ? 0 : col_pos + 1;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 100) $display("ERROR at %0t: %s", $time, msg);
	endtask

	// one byte request; a typed result overrides the predicted one
	task automatic send_byte(input logic [7:0] b, input bit typed, input decoded_t typed_res);
		decoded_t r;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (unfilter_byte(b, r)) decoded_q.push_back(typed ? typed_res : r);
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// tag byte followed by nbytes random data bytes
	task automatic send_row(input logic [7:0] tag, input int nbytes);
		send_byte(tag, 1'b0, '0);
		repeat (nbytes) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// stop sending and let every pending byte and any tag in flight clear the pipe
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_COLORS:  cfg_colors = val[COLORS_W-1:0];
			CFG_BPC:     cfg_bpc = val[BPC_W-1:0];
			CFG_COLUMNS: cfg_columns = val[COLUMNS_W-1:0];
			default: ;
		endcase
		if (idx != CFG_UNUSED) begin
			col_pos = 0;
			clear_hist();
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random register write, mostly small rows and meaningful bit depths
	task automatic write_rand_reg();
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] val;
		int k;
		idx = CFG_IDX_W'($urandom_range(0, 3));
		val = CFG_DAT_W'($urandom);
		case (idx)
			CFG_BPC: begin
				k = $urandom_range(0, 7);
				val[BPC_W-1:0] = (k < 5) ? BPC_W'(1 << k) : BPC_W'($urandom_range(0, 31));
			end
			CFG_COLUMNS: begin
				val = ($urandom_range(0, 15) == 0) ? CFG_DAT_W'($urandom_range(9, 40))
					: CFG_DAT_W'($urandom_range(0, 8));
			end
			default: ;
		endcase
		write_reg(idx, val);
	endtask

	// sink side ready, stalled in random bursts
	always @(posedge clk) begin
		if (snk_stall > 0) begin
			snk_stall <= snk_stall - 1;
			m_tready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
			snk_stall <= $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each decoded byte with the oldest prediction
	always @(posedge clk) begin : check_out
		decoded_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %b bad %b",
					m_tdata, m_tlast, m_tuser));
			end else begin
				want = decoded_q.pop_front();
				if (m_tdata !== want.dec)
					report_mismatch($sformatf("decoded_byte %02h, want %02h", m_tdata, want.dec));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("row_end %b, want %b", m_tlast, want.last));
				if (m_tuser !== want.bad)
					report_mismatch($sformatf("bad_filter %b, want %b", m_tuser, want.bad));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	dir_step_t dir_tab [DIR_N] = '{
		// one-byte rows at reset config, the up row adding onto the prior row's byte
		'{1'b0, '0, 13'(FLT_NONE), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0ff, 1'b1, 8'hff, 1'b1, 1'b0},
		'{1'b0, '0, 13'(FLT_UP), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h001, 1'b1, 8'h00, 1'b1, 1'b0},
		// bad tags pass data through
		'{1'b0, '0, 13'h0ff, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h05a, 1'b1, 8'h5a, 1'b1, 1'b1},
		'{1'b0, '0, 13'(FLT_BAD), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h000, 1'b1, 8'h00, 1'b1, 1'b1},
		// four-byte rows with sub, average and paeth
		'{1'b1, CFG_COLUMNS, 13'd4, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'(FLT_SUB), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h010, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h020, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0f0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h080, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'(FLT_AVG), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0ff, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0ff, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0ff, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0ff, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'(FLT_PAETH), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h001, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h080, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0fe, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h07f, 1'b0, 8'h00, 1'b0, 1'b0},
		// zero colors: row length raised to one byte, left byte zero at row start
		'{1'b1, CFG_COLORS, 13'd0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'(FLT_SUB), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h07f, 1'b1, 8'h7f, 1'b1, 1'b0},
		// upper data bits ignored, unused index does nothing
		'{1'b1, CFG_COLORS, 13'h1ff9, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b1, CFG_UNUSED, 13'h1fff, 1'b0, 8'h00, 1'b0, 1'b0},
		// write mid-row restarts at a tag
		'{1'b0, '0, 13'(FLT_UP), 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h033, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'h0cc, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b1, CFG_BPC, 13'd8, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, '0, 13'(FLT_SUB), 1'b0, 8'h00, 1'b0, 1'b0}
	};

	initial begin : stimulus
		int rand_items;
		int rows;
		int len;
		logic [7:0] tag;
		decoded_t typed_res;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed steps
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_drained();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				typed_res = '{dir_tab[i].dec, dir_tab[i].last, dir_tab[i].bad};
				send_byte(dir_tab[i].val[7:0], dir_tab[i].typed, typed_res);
			end
		end
		send_row(8'h00, row_len() - 1);

		// widest settings: pixel cut to eight bytes, start of a long row cut short
		wait_drained();
		write_reg(CFG_COLORS, 13'h1fff);
		write_reg(CFG_BPC, 13'h1fff);
		write_reg(CFG_COLUMNS, 13'h1fff);
		send_row(8'(FLT_PAETH), 40);

		// back to short rows before the random part
		wait_drained();
		write_reg(CFG_BPC, 13'd8);
		write_reg(CFG_COLUMNS, 13'd4);

		// random phases of well-formed rows, a few cut short by a write
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			wait_drained();
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en <= ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3)) write_rand_reg();
			rows = $urandom_range(1, 4);
			for (int r = 0; r < rows; r++) begin
				tag = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 255))
					: 8'($urandom_range(0, 4));
				len = row_len();
				if (r == rows - 1 && $urandom_range(0, 9) == 0)
					len = $urandom_range(0, len - 1);
				send_row(tag, len);
				rand_items += len + 1;
				if ($urandom_range(0, 5) == 0) wait_drained();
			end
		end

		// closing stretch without any idling
		wait_drained();
		src_idle_en = 1'b0;
		snk_idle_en <= 1'b0;
		repeat (17) @(posedge clk);
		write_reg(CFG_COLORS, 13'd3);
		write_reg(CFG_BPC, 13'd8);
		write_reg(CFG_COLUMNS, 13'd3);
		send_row(8'(FLT_NONE), row_len());
		send_row(8'(FLT_SUB), row_len());
		send_row(8'(FLT_UP), row_len());
		send_row(8'(FLT_AVG), row_len());
		send_row(8'(FLT_PAETH), row_len());
		wait_drained();
		repeat (8) @(posedge clk);

		if (err_count == 0 && decoded_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### png_row_unfilter_unit.f
rtl/pru_pkg.sv
rtl/pru_ram.sv
rtl/pru_recon.sv
rtl/png_row_unfilter_unit.sv
tb/sv/png_row_unfilter_unit_tb.sv
